// ----- rtl/core/bsoa_pkg.sv -----
// Shared types, operation codes and the second-table mix constants of the byte scramble unit.
`timescale 1ns / 1ps

package bsoa_pkg;

   localparam int unsigned CODE_W  = 6;
   localparam int unsigned INDEX_W = 5;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ROT_W   = 3;

   // First table
   localparam logic [CODE_W-1:0] OP_D_XOR_K       = 6'd0;
   localparam logic [CODE_W-1:0] OP_D_ADD_K       = 6'd1;
   localparam logic [CODE_W-1:0] OP_ROR_K7        = 6'd2;
   localparam logic [CODE_W-1:0] OP_ROR_KZ        = 6'd3;
   localparam logic [CODE_W-1:0] OP_ROR_DZ_KZ     = 6'd4;
   localparam logic [CODE_W-1:0] OP_NOT_ROR_K7    = 6'd5;
   localparam logic [CODE_W-1:0] OP_K_XOR_DZ      = 6'd6;
   localparam logic [CODE_W-1:0] OP_K_ADD_DZ      = 6'd7;
   localparam logic [CODE_W-1:0] OP_K_XOR_SUM     = 6'd8;
   localparam logic [CODE_W-1:0] OP_K_ADD_XOR     = 6'd9;
   localparam logic [CODE_W-1:0] OP_K_XOR_ROR_KZ  = 6'd10;
   localparam logic [CODE_W-1:0] OP_K_XOR_ROR_K7  = 6'd11;
   localparam logic [CODE_W-1:0] OP_K_ADD_ROR_K7  = 6'd12;
   localparam logic [CODE_W-1:0] OP_K_ADD_ROR_KZ  = 6'd13;
   localparam logic [CODE_W-1:0] OP_ADD_ROR_LO    = 6'd14;
   localparam logic [CODE_W-1:0] OP_ADD_ROR_HI    = 6'd20;
   localparam logic [CODE_W-1:0] OP_XOR_ROR_LO    = 6'd21;
   localparam logic [CODE_W-1:0] OP_XOR_ROR_HI    = 6'd27;
   localparam logic [CODE_W-1:0] OP_XOR_ADD_ROR5  = 6'd28;
   localparam logic [CODE_W-1:0] OP_XOR_ADD_ROR3  = 6'd29;
   localparam logic [CODE_W-1:0] OP_ADD_XOR_ROR3  = 6'd30;
   localparam logic [CODE_W-1:0] OP_ADD_XOR_ROR5  = 6'd31;
   // Second table: all but two use the mix table below
   localparam logic [CODE_W-1:0] OP_D_XOR_KSHL    = 6'd61;
   localparam logic [CODE_W-1:0] OP_K_XOR_DSHL    = 6'd62;

   // Offsets that turn a ranged code into its rotate amount
   localparam logic [CODE_W-1:0] ADD_ROR_BASE     = 6'd13;
   localparam logic [CODE_W-1:0] XOR_ROR_BASE     = 6'd20;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] key;
      logic [BYTE_W-1:0] data;
   } op_type;

   typedef struct packed {
      logic [ROT_W-1:0]  rot;
      logic [BYTE_W-1:0] or_mask;
      logic [BYTE_W-1:0] xor_mask;
   } mix_type;

   // k ^ (ror8(d, rot) | or_mask) ^ xor_mask, by index within the second table
   function automatic mix_type mix_entry(input logic [INDEX_W-1:0] idx);
      mix_type e;
      case (idx)
         5'd0:    e = '{3'd3, 8'h00, 8'h1F};
         5'd1:    e = '{3'd5, 8'h00, 8'h07};
         5'd2:    e = '{3'd2, 8'h00, 8'h3F};
         5'd3:    e = '{3'd6, 8'h00, 8'h03};
         5'd4:    e = '{3'd2, 8'h00, 8'hC0};
         5'd5:    e = '{3'd5, 8'h00, 8'hF8};
         5'd6:    e = '{3'd6, 8'h00, 8'hFC};
         5'd7:    e = '{3'd3, 8'h00, 8'hE0};
         5'd8:    e = '{3'd6, 8'h00, 8'h01};
         5'd9:    e = '{3'd2, 8'h00, 8'h17};
         5'd10:   e = '{3'd3, 8'h00, 8'h0B};
         5'd11:   e = '{3'd5, 8'h00, 8'h02};
         5'd12:   e = '{3'd2, 8'h00, 8'h0D};
         5'd13:   e = '{3'd3, 8'h00, 8'h06};
         5'd14:   e = '{3'd4, 8'h00, 8'h03};
         5'd15:   e = '{3'd1, 8'h00, 8'h1B};
         5'd16:   e = '{3'd4, 8'h05, 8'h02};
         5'd17:   e = '{3'd3, 8'h0B, 8'h04};
         5'd18:   e = '{3'd5, 8'h02, 8'h01};
         5'd19:   e = '{3'd6, 8'h01, 8'h00};
         5'd20:   e = '{3'd1, 8'h1B, 8'h24};
         5'd21:   e = '{3'd7, 8'h00, 8'h00};
         5'd22:   e = '{3'd3, 8'h06, 8'h09};
         5'd23:   e = '{3'd5, 8'h01, 8'h02};
         5'd24:   e = '{3'd4, 8'h06, 8'h01};
         5'd25:   e = '{3'd5, 8'h03, 8'h00};
         5'd26:   e = '{3'd6, 8'h00, 8'h01};
         5'd27:   e = '{3'd2, 8'h19, 8'h06};
         5'd28:   e = '{3'd4, 8'h0A, 8'h05};
         5'd31:   e = '{3'd6, 8'h02, 8'h01};
         default: e = '{3'd0, 8'h00, 8'h00}; // shift ops, decoded apart
      endcase
      return e;
   endfunction

endpackage

// ----- rtl/core/bsoa_if.sv -----
// Request and response channel interfaces of the byte scramble unit.
`timescale 1ns / 1ps

interface bsoa_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] req_type;
   logic [7:0] key_byte;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output key_byte, output data_byte,
                   input ready);
   modport sink   (input valid, input req_type, input key_byte, input data_byte,
                   output ready);
endinterface

interface bsoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_byte;

   modport source (output valid, output result_byte, input ready);
   modport sink   (input valid, input result_byte, output ready);
endinterface

// ----- rtl/core/bsoa_alu.sv -----
// Combinational byte operation decoder for both operation tables.
`timescale 1ns / 1ps

module bsoa_alu (
   input  bsoa_pkg::op_type     op,
   output logic [7:0]           result
);
   import bsoa_pkg::*;

   function automatic logic [BYTE_W-1:0] ror8(input logic [BYTE_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
      logic [2*BYTE_W-1:0] w;
      w = {v, v} >> n;
      return w[BYTE_W-1:0];
   endfunction

   logic              kz;
   logic              dz;
   logic [ROT_W-1:0]  k7;
   logic [ROT_W-1:0]  kz_rot;
   logic [CODE_W-1:0] add_rot;
   logic [CODE_W-1:0] xor_rot;
   mix_type           mix;
   logic [BYTE_W-1:0] k;
   logic [BYTE_W-1:0] d;

   assign k       = op.key;
   assign d       = op.data;
   assign kz      = (k == '0);
   assign dz      = (d == '0);
   assign k7      = k[ROT_W-1:0];
   assign kz_rot  = {{(ROT_W-1){1'b0}}, kz};
   assign add_rot = op.code - ADD_ROR_BASE;
   assign xor_rot = op.code - XOR_ROR_BASE;
   assign mix     = mix_entry(op.code[INDEX_W-1:0]);

   always_comb begin
      case (op.code) inside
         OP_D_XOR_K:      result = d ^ k;
         OP_D_ADD_K:      result = d + k;
         OP_ROR_K7:       result = ror8(d, k7);
         OP_ROR_KZ:       result = ror8(d, kz_rot);
         OP_ROR_DZ_KZ:    result = ror8({{(BYTE_W-1){1'b0}}, dz}, kz_rot);
         OP_NOT_ROR_K7:   result = ror8(~d, k7);
         OP_K_XOR_DZ:     result = k ^ {{(BYTE_W-1){1'b0}}, dz};
         OP_K_ADD_DZ:     result = k + {{(BYTE_W-1){1'b0}}, dz};
         OP_K_XOR_SUM:    result = k ^ (d + k);
         OP_K_ADD_XOR:    result = k + (d ^ k);
         OP_K_XOR_ROR_KZ: result = k ^ ror8(d, kz_rot);
         OP_K_XOR_ROR_K7: result = k ^ ror8(d, k7);
         OP_K_ADD_ROR_K7: result = k + ror8(d, k7);
         OP_K_ADD_ROR_KZ: result = k + ror8(d, kz_rot);
         [OP_ADD_ROR_LO:OP_ADD_ROR_HI]: result = k + ror8(d, add_rot[ROT_W-1:0]);
         [OP_XOR_ROR_LO:OP_XOR_ROR_HI]: result = k ^ ror8(d, xor_rot[ROT_W-1:0]);
         OP_XOR_ADD_ROR5: result = k ^ (k + ror8(d, 3'd5));
         OP_XOR_ADD_ROR3: result = k ^ (k + ror8(d, 3'd3));
         OP_ADD_XOR_ROR3: result = k + (k ^ ror8(d, 3'd3));
         OP_ADD_XOR_ROR5: result = k + (k ^ ror8(d, 3'd5));
         OP_D_XOR_KSHL:   result = d ^ {k[2:0], 5'h1F};
         OP_K_XOR_DSHL:   result = k ^ ({d[4:0], 3'b000} + 8'h07);
         default:         result = k ^ (ror8(d, mix.rot) | mix.or_mask) ^ mix.xor_mask;
      endcase
   end

endmodule

// ----- rtl/core/byte_scramble_op_alu_top.sv -----
// Top level of the byte scramble operation unit: table select, input and result registers.
//
//   channel     direction  handshake        payload
//   req_chan    in         valid / ready    req_type[4:0], key_byte[7:0], data_byte[7:0]
//   rsp_chan    out        valid / ready    result_byte[7:0]
//   csr_wr_*    in         write enable     table_select (bit 0 of csr_wr_data)
//
// One request per cycle sustained while the response side takes results; a taken request
// is held in the input register and then decoded into the result register, which drives the response.
// Synchronous active-high reset clears the valid flags and table_select.
// A stalled response holds in the result register while the input register can still fill;
// ready drops only when both registers are full and the response side is stalled.
`timescale 1ns / 1ps

module byte_scramble_op_alu_top (
   input  logic           clock,
   input  logic           reset,
   bsoa_req_if.sink       req_chan,
   bsoa_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);
   import bsoa_pkg::*;

   logic              table_select_ff;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   op_type            s1_op_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [BYTE_W-1:0] alu_byte;
   logic              s1_ready;
   logic              s2_ready;
   logic              req_fire;
   logic              s1_fire;

   assign s2_ready = !rsp_valid_ff || rsp_chan.ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_fire = req_chan.valid && s1_ready;
   assign s1_fire  = s1_valid_ff && s2_ready;

   assign req_chan.ready       = s1_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_byte = rsp_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_select_ff <= 1'b0;
      end else if (csr_wr_en) begin
         table_select_ff <= csr_wr_data;
      end
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= '{code: {table_select_ff, req_chan.req_type},
                       key:  req_chan.key_byte,
                       data: req_chan.data_byte};
      end
      if (s1_fire) begin
         rsp_byte_ff <= alu_byte;
      end
   end

   bsoa_alu u_alu (
      .op     (s1_op_ff),
      .result (alu_byte)
   );

   // Taken request lands in the input register with the table bit in front
   a_req_capture: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff && s1_op_ff.code[INDEX_W-1:0] == $past(req_chan.req_type)
                   && s1_op_ff.key == $past(req_chan.key_byte))
      else $error("request not captured in input register");

   // Advancing item shows up as the decoded result
   a_rsp_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff && rsp_byte_ff == $past(alu_byte))
      else $error("result register missed the decoded byte");

   // Back-pressure only with both registers full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !s1_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_chan.ready)
      else $error("ready low with a free register");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for the byte scramble operation unit: both tables, random traffic and stalls.
`timescale 1ns / 1ps

module tb_top;
   import bsoa_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic [BYTE_W-1:0]  key;
      logic [BYTE_W-1:0]  data;
   } scramble_req_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] result;
   } byte_check_type;

   typedef struct packed {
      logic [ROT_W-1:0]  rot;
      logic [BYTE_W-1:0] or_bits;
      logic [BYTE_W-1:0] xor_bits;
   } mix_rule_type;

   localparam logic [INDEX_W-1:0] LAST_INDEX = '1;
   localparam int unsigned        QUIET_LIMIT = 2000;
   localparam int unsigned        PHASE_REQS  = 200;
   localparam int unsigned        LONG_HOLD   = 60;

   // Second table: k ^ (ror(d, rot) | or_bits) ^ xor_bits; the two shift ops are decoded apart
   localparam mix_rule_type MIX_RULES [0:31] = '{
      '{3'd3, 8'h00, 8'h1F}, '{3'd5, 8'h00, 8'h07}, '{3'd2, 8'h00, 8'h3F}, '{3'd6, 8'h00, 8'h03},
      '{3'd2, 8'h00, 8'hC0}, '{3'd5, 8'h00, 8'hF8}, '{3'd6, 8'h00, 8'hFC}, '{3'd3, 8'h00, 8'hE0},
      '{3'd6, 8'h00, 8'h01}, '{3'd2, 8'h00, 8'h17}, '{3'd3, 8'h00, 8'h0B}, '{3'd5, 8'h00, 8'h02},
      '{3'd2, 8'h00, 8'h0D}, '{3'd3, 8'h00, 8'h06}, '{3'd4, 8'h00, 8'h03}, '{3'd1, 8'h00, 8'h1B},
      '{3'd4, 8'h05, 8'h02}, '{3'd3, 8'h0B, 8'h04}, '{3'd5, 8'h02, 8'h01}, '{3'd6, 8'h01, 8'h00},
      '{3'd1, 8'h1B, 8'h24}, '{3'd7, 8'h00, 8'h00}, '{3'd3, 8'h06, 8'h09}, '{3'd5, 8'h01, 8'h02},
      '{3'd4, 8'h06, 8'h01}, '{3'd5, 8'h03, 8'h00}, '{3'd6, 8'h00, 8'h01}, '{3'd2, 8'h19, 8'h06},
      '{3'd4, 8'h0A, 8'h05}, '{3'd0, 8'h00, 8'h00}, '{3'd0, 8'h00, 8'h00}, '{3'd6, 8'h02, 8'h01}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   bsoa_req_if req_bus ();
   bsoa_rsp_if rsp_bus ();

   byte_scramble_op_alu_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   scramble_req_type pending_reqs [$];
   byte_check_type   expected_bytes [$];
   logic             table_sel;
   int unsigned      err_count;
   int unsigned      reqs_taken;
   int unsigned      results_seen;
   int unsigned      table_writes;

   always #5 clock = ~clock;

   function automatic logic [BYTE_W-1:0] rotr8(input logic [BYTE_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
      logic [2*BYTE_W-1:0] w;
      w = {v, v} >> n;
      return w[BYTE_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] scramble_byte(input logic [CODE_W-1:0] code,
                                                       input logic [BYTE_W-1:0] k,
                                                       input logic [BYTE_W-1:0] d);
      logic [BYTE_W-1:0] kz;
      logic [BYTE_W-1:0] dz;
      logic [ROT_W-1:0]  k7;
      logic [CODE_W-1:0] amt;
      logic [BYTE_W-1:0] r;
      mix_rule_type      m;
      kz = (k == 8'h00) ? 8'h01 : 8'h00;
      dz = (d == 8'h00) ? 8'h01 : 8'h00;
      k7 = k[ROT_W-1:0];
      m  = MIX_RULES[code[INDEX_W-1:0]];
      if (code >= OP_ADD_ROR_LO && code <= OP_ADD_ROR_HI) begin
         amt = code - ADD_ROR_BASE;
         r = k + rotr8(d, amt[ROT_W-1:0]);
      end else if (code >= OP_XOR_ROR_LO && code <= OP_XOR_ROR_HI) begin
         amt = code - XOR_ROR_BASE;
         r = k ^ rotr8(d, amt[ROT_W-1:0]);
      end else begin
         case (code)
            OP_D_XOR_K:      r = d ^ k;
            OP_D_ADD_K:      r = d + k;
            OP_ROR_K7:       r = rotr8(d, k7);
            OP_ROR_KZ:       r = rotr8(d, kz[ROT_W-1:0]);
            OP_ROR_DZ_KZ:    r = rotr8(dz, kz[ROT_W-1:0]);
            OP_NOT_ROR_K7:   r = rotr8(~d, k7);
            OP_K_XOR_DZ:     r = k ^ dz;
            OP_K_ADD_DZ:     r = k + dz;
            OP_K_XOR_SUM:    r = k ^ (d + k);
            OP_K_ADD_XOR:    r = k + (d ^ k);
            OP_K_XOR_ROR_KZ: r = k ^ rotr8(d, kz[ROT_W-1:0]);
            OP_K_XOR_ROR_K7: r = k ^ rotr8(d, k7);
            OP_K_ADD_ROR_K7: r = k + rotr8(d, k7);
            OP_K_ADD_ROR_KZ: r = k + rotr8(d, kz[ROT_W-1:0]);
            OP_XOR_ADD_ROR5: r = k ^ (k + rotr8(d, 3'd5));
            OP_XOR_ADD_ROR3: r = k ^ (k + rotr8(d, 3'd3));
            OP_ADD_XOR_ROR3: r = k + (k ^ rotr8(d, 3'd3));
            OP_ADD_XOR_ROR5: r = k + (k ^ rotr8(d, 3'd5));
            OP_D_XOR_KSHL:   r = d ^ ((k << 5) | 8'h1F);
            OP_K_XOR_DSHL:   r = k ^ ((d << 3) + 8'h07);
            default:         r = k ^ (rotr8(d, m.rot) | m.or_bits) ^ m.xor_bits;
         endcase
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // request driver
   int unsigned      req_gap;
   bit               req_calm;
   scramble_req_type req_next;
   byte_check_type   req_check;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            req_check.op.code   = {table_sel, req_bus.req_type};
            req_check.op.key    = req_bus.key_byte;
            req_check.op.data   = req_bus.data_byte;
            req_check.result    = scramble_byte(req_check.op.code, req_bus.key_byte,
                                                req_bus.data_byte);
            expected_bytes.push_back(req_check);
            reqs_taken++;
         end
         if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_next = pending_reqs.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.req_type  <= req_next.idx;
               req_bus.key_byte  <= req_next.key;
               req_bus.data_byte <= req_next.data;
               req_gap = req_calm ? 0 : idle_len();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   int unsigned    rsp_stall;
   int unsigned    rsp_hold;
   bit             rsp_calm;
   byte_check_type rsp_check;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
         rsp_hold  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected result: expected none, got %02h",
                        $time, rsp_bus.result_byte);
               err_count++;
            end else begin
               rsp_check = expected_bytes.pop_front();
               if (rsp_check.result !== rsp_bus.result_byte) begin
                  $display("%0t: op %0d key %02h data %02h: expected %02h, got %02h",
                           $time, rsp_check.op.code, rsp_check.op.key, rsp_check.op.data,
                           rsp_check.result, rsp_bus.result_byte);
                  err_count++;
               end
            end
            // long hold-off so both registers fill and the request side backs up
            if (results_seen == 300 || results_seen == 1000) rsp_hold = LONG_HOLD;
         end
         if ($urandom_range(0, 149) == 0) rsp_calm = !rsp_calm;
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall = idle_len();
         end
      end
   end

   // watchdog on traffic
   int unsigned quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_bytes.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic push_req(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] key,
                           input logic [BYTE_W-1:0] data);
      scramble_req_type r;
      r.idx  = idx;
      r.key  = key;
      r.data = data;
      pending_reqs.push_back(r);
   endtask

   // wait for the unit to drain, then let its input and result registers settle
   task automatic settle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_table(input logic sel);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sel;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      table_sel = sel;
      table_writes++;
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = '0;
      req_bus.key_byte  = '0;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
      table_sel         = 1'b0;
      err_count         = 0;
      reqs_taken        = 0;
      results_seen      = 0;
      table_writes      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first table: extremes, carries, zero tests and rotate by zero
      write_table(1'b0);
      push_req(OP_D_XOR_K[INDEX_W-1:0],      8'hFF, 8'h00);
      push_req(OP_D_ADD_K[INDEX_W-1:0],      8'h80, 8'h80);
      push_req(OP_D_ADD_K[INDEX_W-1:0],      8'hFF, 8'hFF);
      push_req(OP_ROR_K7[INDEX_W-1:0],       8'h08, 8'h5A);
      push_req(OP_ROR_KZ[INDEX_W-1:0],       8'h00, 8'h81);
      push_req(OP_ROR_DZ_KZ[INDEX_W-1:0],    8'h00, 8'h00);
      push_req(OP_NOT_ROR_K7[INDEX_W-1:0],   8'h07, 8'h00);
      push_req(OP_K_XOR_DZ[INDEX_W-1:0],     8'hFF, 8'h00);
      push_req(OP_K_ADD_DZ[INDEX_W-1:0],     8'hFF, 8'h00);
      push_req(OP_ADD_ROR_HI[INDEX_W-1:0],   8'hFF, 8'hFF);
      push_req(OP_XOR_ADD_ROR5[INDEX_W-1:0], 8'hFF, 8'hFF);
      push_req(OP_ADD_XOR_ROR5[INDEX_W-1:0], 8'h00, 8'hFF);
      settle();

      // second table: shift ops with bits shifted out, mix ops at the extremes
      write_table(1'b1);
      push_req(OP_D_XOR_KSHL[INDEX_W-1:0], 8'hFF, 8'h00);
      push_req(OP_D_XOR_KSHL[INDEX_W-1:0], 8'h00, 8'hFF);
      push_req(OP_K_XOR_DSHL[INDEX_W-1:0], 8'h00, 8'hFF);
      push_req(OP_K_XOR_DSHL[INDEX_W-1:0], 8'hFF, 8'hFF);
      push_req(LAST_INDEX, 8'h00, 8'h00);
      push_req(LAST_INDEX, 8'hFF, 8'hFF);
      push_req('0, 8'h00, 8'hFF);
      push_req(INDEX_W'($urandom_range(0, LAST_INDEX)), 8'hFF, 8'h00);
      push_req(INDEX_W'($urandom_range(0, LAST_INDEX)), 8'h00, 8'h00);
      push_req(INDEX_W'($urandom_range(0, LAST_INDEX)), 8'hFF, 8'hFF);
      settle();

      // random traffic, switching tables between phases
      for (int p = 0; p < 7; p++) begin
         write_table(p % 2 == 1);
         for (int i = 0; i < PHASE_REQS; i++)
            push_req(INDEX_W'($urandom_range(0, LAST_INDEX)), rand_byte(), rand_byte());
         settle();
      end

      $display("Checked %0d results for %0d requests across %0d table switches.",
               results_seen, reqs_taken, table_writes);
      $display("Both operation tables driven under random gaps and long response stalls.");
      if (err_count == 0 && expected_bytes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
